// ===== rtl/lpcp_pkg.sv =====
// Shared constants and register indexes for the lidar point projection block.
`default_nettype none
package lpcp_pkg;
   localparam int unsigned CSR_IDX_W      = 3;
   localparam int unsigned CSR_DATA_W     = 64;
   localparam int unsigned NUM_COEF_PAIRS = 6;
   localparam int unsigned COORD_W        = 32;
   localparam int unsigned PIX_W          = 16;
   localparam int unsigned COLOR_W        = 8;
   localparam int unsigned COLOR_T_W      = 13;   // 255 * 20 fits in 13 bits
   localparam int unsigned RECIP20_SHIFT  = 16;
   localparam logic [15:0] RECIP20        = 16'd3277; // ceil(2^16 / 20)
   localparam logic [7:0]  COLOR_FULL     = 8'd255;
   localparam int unsigned SPAN_METRES    = 20;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PAIR_0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PAIR_1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PAIR_2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PAIR_3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PAIR_4  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_PAIR_5  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_SIZE   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LIMITS = 3'd7;

   localparam logic [31:0] IMAGE_SIZE_RESET   = 32'd24642777;            // 376 x 1241
   localparam logic [63:0] RANGE_LIMITS_RESET = 64'd112589990684263055;  // 400, 655
endpackage
`default_nettype wire

// ===== rtl/lidar_point_camera_projection_top.sv =====
// Lidar point to camera pixel projection, one point per clock.
// Pipeline from req word accept to rsp_tvalid: 3 arithmetic stages,
// 16 restoring-division stages, one output register.
// Throughput: one word per cycle; the whole pipe holds while the output word waits.
// Reset (synchronous, active high) clears all valid bits and loads register defaults.
`default_nettype none
module lidar_point_camera_projection_top #(
   parameter int unsigned COORD_FRAC_BITS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // csr write port
   input  wire logic          csr_wr_en,
   input  wire logic [2:0]    csr_index,
   input  wire logic [63:0]   csr_wdata,
   // point input: point_x [31:0], point_y [63:32], point_z [95:64]
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [95:0]   req_tdata,
   // result: pixel_col [15:0], pixel_row [31:16], red_level [39:32],
   //         green_level [47:40]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [47:0]        rsp_tdata,
   // result flag: in_view [0]
   output logic               rsp_tuser
);
   localparam int unsigned F      = COORD_FRAC_BITS;
   localparam int unsigned ACC_W  = 66 - F;               // row sum width
   localparam int unsigned QB     = lpcp_pkg::PIX_W;      // quotient bits
   localparam int unsigned WIDE_W = ACC_W + QB;
   localparam int unsigned NSTG   = QB;
   localparam logic [33:0] SPAN   = 34'(lpcp_pkg::SPAN_METRES) << F;

   // ---------------- configuration registers ----------------
   logic [63:0] coef_ff [lpcp_pkg::NUM_COEF_PAIRS];
   logic [31:0] image_size_ff;
   logic [63:0] range_limits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < lpcp_pkg::NUM_COEF_PAIRS; i++) coef_ff[i] <= '0;
         image_size_ff   <= lpcp_pkg::IMAGE_SIZE_RESET;
         range_limits_ff <= lpcp_pkg::RANGE_LIMITS_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == lpcp_pkg::CSR_IMAGE_SIZE) begin
            image_size_ff <= csr_wdata[31:0];
         end else if (csr_index == lpcp_pkg::CSR_RANGE_LIMITS) begin
            range_limits_ff <= csr_wdata;
         end else begin
            coef_ff[csr_index] <= csr_wdata;
         end
      end
   end

   // matrix coefficient: pair 2r high = col0, low = col1; pair 2r+1 high = col2, low = col3
   logic signed [31:0] cf [3][4];
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         cf[r][0] = coef_ff[2*r][63:32];
         cf[r][1] = coef_ff[2*r][31:0];
         cf[r][2] = coef_ff[2*r+1][63:32];
         cf[r][3] = coef_ff[2*r+1][31:0];
      end
   end

   // global advance: the pipe moves whenever the output register can take a word
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   logic signed [31:0] px, py, pz;
   assign px = req_tdata[31:0];
   assign py = req_tdata[63:32];
   assign pz = req_tdata[95:64];

   // ---------------- stage 1: products ----------------
   logic               v1_ff;
   logic signed [63:0] prod_ff [3][3];
   logic        [63:0] sq_ff [3];
   logic signed [31:0] x1_ff;
   logic        [33:0] absd1_ff;
   logic signed [63:0] prod_in [3][3];
   logic signed [63:0] sq_in [3];
   logic signed [33:0] d_in;
   logic        [33:0] absd_in;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         prod_in[r][0] = 64'(cf[r][0]) * 64'(px);
         prod_in[r][1] = 64'(cf[r][1]) * 64'(py);
         prod_in[r][2] = 64'(cf[r][2]) * 64'(pz);
      end
      sq_in[0] = 64'(px) * 64'(px);
      sq_in[1] = 64'(py) * 64'(py);
      sq_in[2] = 64'(pz) * 64'(pz);
      d_in     = 34'(px) - $signed(SPAN);
      absd_in  = d_in[33] ? 34'(-d_in) : 34'(d_in);
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_in;
         for (int i = 0; i < 3; i++) sq_ff[i] <= 64'(sq_in[i]);
         x1_ff    <= px;
         absd1_ff <= absd_in;
      end
   end

   // ---------------- stage 2: row sums, range, color numerators ----------------
   logic                   v2_ff;
   logic signed [ACC_W-1:0] row2_ff [3];
   logic        [63:0]      dist2_ff;
   logic                   xgt2_ff;
   logic                   near2_ff;   // |x - 20 m| below 20 m
   logic [lpcp_pkg::COLOR_T_W-1:0] tred2_ff, tgrn2_ff;

   logic signed [ACC_W-1:0] row_in [3];
   logic signed [63:0]      shp;
   logic        [41:0]      nred, ngrn;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         row_in[r] = ACC_W'(cf[r][3]);
         for (int c = 0; c < 3; c++) begin
            shp       = prod_ff[r][c] >>> F;
            row_in[r] = row_in[r] + shp[ACC_W-1:0];
         end
      end
      nred = 42'(absd1_ff) * 42'd255;
      ngrn = 42'(SPAN - absd1_ff) * 42'd255;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (en) begin
         row2_ff  <= row_in;
         dist2_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         xgt2_ff  <= x1_ff > $signed(range_limits_ff[31:0]);
         near2_ff <= absd1_ff < SPAN;
         tred2_ff <= lpcp_pkg::COLOR_T_W'(nred >> F);
         tgrn2_ff <= lpcp_pkg::COLOR_T_W'(ngrn >> F);
      end
   end

   // ---------------- stage 3: divide setup, colors ----------------
   typedef struct packed {
      logic [ACC_W-1:0] rem0;
      logic [ACC_W-1:0] rem1;
      logic [ACC_W-1:0] den;
      logic [QB-1:0]    q0;
      logic [QB-1:0]    q1;
      logic             ok;
      logic             neg0;
      logic             neg1;
      logic [lpcp_pkg::COLOR_W-1:0] red;
      logic [lpcp_pkg::COLOR_W-1:0] green;
   } div_type;

   div_type            dv_ff [NSTG+1];
   logic               dvv_ff [NSTG+1];
   div_type            s3_in;
   logic [ACC_W-1:0]   mag0, mag1;
   logic [WIDE_W-1:0]  den_top;
   logic [63:0]        maxr2;
   logic [28:0]        qred, qgrn;

   always_comb begin
      mag0    = row2_ff[0][ACC_W-1] ? ACC_W'(-row2_ff[0]) : ACC_W'(row2_ff[0]);
      mag1    = row2_ff[1][ACC_W-1] ? ACC_W'(-row2_ff[1]) : ACC_W'(row2_ff[1]);
      den_top = WIDE_W'(row2_ff[2]) << QB;
      maxr2   = {32'd0, range_limits_ff[63:32]} << F;
      qred    = (29'(tred2_ff) * 29'(lpcp_pkg::RECIP20)) >> lpcp_pkg::RECIP20_SHIFT;
      qgrn    = (29'(tgrn2_ff) * 29'(lpcp_pkg::RECIP20)) >> lpcp_pkg::RECIP20_SHIFT;
      s3_in.rem0  = mag0;
      s3_in.rem1  = mag1;
      s3_in.den   = row2_ff[2];
      s3_in.q0    = '0;
      s3_in.q1    = '0;
      // positive depth, quotients below 2^16, x and range tests
      s3_in.ok    = !row2_ff[2][ACC_W-1] && (row2_ff[2] != '0) &&
                    (WIDE_W'(mag0) < den_top) && (WIDE_W'(mag1) < den_top) &&
                    xgt2_ff && (dist2_ff < maxr2);
      s3_in.neg0  = row2_ff[0][ACC_W-1];
      s3_in.neg1  = row2_ff[1][ACC_W-1];
      s3_in.red   = near2_ff ? qred[7:0] : lpcp_pkg::COLOR_FULL;
      s3_in.green = near2_ff ? qgrn[7:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) dvv_ff[0] <= 1'b0;
      else if (en) dvv_ff[0] <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (en) dv_ff[0] <= s3_in;
   end

   // ---------------- restoring division, one quotient bit per stage ----------------
   for (genvar k = 0; k < NSTG; k++) begin : g_div
      localparam int unsigned B = NSTG - 1 - k;
      div_type          nx_in;
      logic [WIDE_W-1:0] dsh;
      logic             ge0, ge1;
      always_comb begin
         nx_in = dv_ff[k];
         dsh   = WIDE_W'(dv_ff[k].den) << B;
         ge0   = WIDE_W'(dv_ff[k].rem0) >= dsh;
         ge1   = WIDE_W'(dv_ff[k].rem1) >= dsh;
         if (ge0) begin
            nx_in.rem0  = dv_ff[k].rem0 - dsh[ACC_W-1:0];
            nx_in.q0[B] = 1'b1;
         end
         if (ge1) begin
            nx_in.rem1  = dv_ff[k].rem1 - dsh[ACC_W-1:0];
            nx_in.q1[B] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dvv_ff[k+1] <= 1'b0;
         else if (en) dvv_ff[k+1] <= dvv_ff[k];
      end
      always_ff @(posedge clock) begin
         if (en) dv_ff[k+1] <= nx_in;
      end
   end

   // ---------------- output register ----------------
   div_type fin;
   logic    view_in;
   logic    rsp_tvalid_ff;
   logic [47:0] rsp_tdata_ff;
   logic    rsp_tuser_ff;

   always_comb begin
      fin     = dv_ff[NSTG];
      // a negative dividend is only acceptable when it truncates to zero
      view_in = fin.ok && !(fin.neg0 && fin.q0 != '0) && !(fin.neg1 && fin.q1 != '0) &&
                (fin.q0 < image_size_ff[15:0]) && (fin.q1 < image_size_ff[31:16]);
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid_ff <= 1'b0;
      else if (en) rsp_tvalid_ff <= dvv_ff[NSTG];
   end
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= {fin.green, fin.red, {QB{view_in}} & fin.q1, {QB{view_in}} & fin.q0};
         rsp_tuser_ff <= view_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
endmodule
`default_nettype wire
